/* sv/blz_pkg.sv */
// Shared constants, types and command format for the backward LZ decompressor.
// No dependencies; used by every module of the block.
`default_nettype none

package blz_pkg;

	localparam int WINDOW_DEPTH    = 8192;
	localparam int WIN_AW          = $clog2(WINDOW_DEPTH);
	localparam int CNT_W           = $clog2(WINDOW_DEPTH + 1);
	localparam int QDEPTH          = 4;
	localparam int Q_AW            = $clog2(QDEPTH);
	localparam int Q_CW            = $clog2(QDEPTH + 1);
	localparam int LEN_BIAS        = 3;
	localparam int DIST_BIAS       = 3;
	localparam int TOKENS_PER_FLAG = 8;

	typedef logic [WIN_AW-1:0] win_addr_t;
	typedef logic [WIN_AW:0]   win_ext_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [12:0]       dist_t;
	typedef logic [4:0]        rem_t;
	typedef logic [Q_AW-1:0]   q_addr_t;
	typedef logic [Q_CW-1:0]   q_cnt_t;

	typedef enum logic [2:0] {
		PH_FLAG  = 3'b001,
		PH_TOKEN = 3'b010,
		PH_REFLO = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		CMD_LIT = 2'd0,
		CMD_REF = 2'd1,
		CMD_CLR = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic [3:0]  len_code;
		logic [11:0] dist_code;
		logic        fin;
	} cmd_t;

endpackage

`default_nettype wire

/* sv/blz_front.sv */
// Front end: parses flag bytes and tokens, issues literal/reference/clear commands.
// Depends on blz_pkg.
`default_nettype none

module blz_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_byte,
	input  wire logic          in_final,
	output logic               cmd_valid,
	input  wire logic          cmd_ready,
	output blz_pkg::cmd_t      cmd
);

	blz_pkg::phase_t phase_q;
	logic [7:0]      flag_q;
	logic [3:0]      tl_q;
	logic [7:0]      hi_q;
	logic            accept;
	logic [3:0]      tl_next;

	assign in_ready = cmd_ready;
	assign accept   = in_valid && cmd_ready;
	assign tl_next  = (tl_q != 4'd0) ? tl_q - 4'd1 : tl_q;

	always_comb begin
		cmd.kind      = blz_pkg::CMD_CLR;
		cmd.data      = in_byte;
		cmd.len_code  = hi_q[7:4];
		cmd.dist_code = {hi_q[3:0], in_byte};
		cmd.fin       = in_final;
		cmd_valid     = 1'b0;
		case (phase_q)
			blz_pkg::PH_TOKEN: begin
				if (!flag_q[7]) begin
					cmd.kind  = blz_pkg::CMD_LIT;
					cmd_valid = accept;
				end else begin
					cmd_valid = accept && in_final;
				end
			end
			blz_pkg::PH_REFLO: begin
				cmd.kind  = blz_pkg::CMD_REF;
				cmd_valid = accept;
			end
			default: begin
				cmd_valid = accept && in_final;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= blz_pkg::PH_FLAG;
			flag_q  <= '0;
			tl_q    <= '0;
			hi_q    <= '0;
		end else if (accept) begin
			if (in_final) begin
				phase_q <= blz_pkg::PH_FLAG;
				flag_q  <= '0;
				tl_q    <= '0;
				hi_q    <= '0;
			end else begin
				case (phase_q)
					blz_pkg::PH_TOKEN: begin
						if (!flag_q[7]) begin
							flag_q  <= {flag_q[6:0], 1'b0};
							tl_q    <= tl_next;
							phase_q <= (tl_next == 4'd0) ? blz_pkg::PH_FLAG : blz_pkg::PH_TOKEN;
						end else begin
							hi_q    <= in_byte;
							phase_q <= blz_pkg::PH_REFLO;
						end
					end
					blz_pkg::PH_REFLO: begin
						flag_q  <= {flag_q[6:0], 1'b0};
						tl_q    <= tl_next;
						phase_q <= (tl_next == 4'd0) ? blz_pkg::PH_FLAG : blz_pkg::PH_TOKEN;
					end
					default: begin
						flag_q  <= in_byte;
						tl_q    <= 4'(blz_pkg::TOKENS_PER_FLAG);
						phase_q <= blz_pkg::PH_TOKEN;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

/* sv/blz_queue.sv */
// Small command queue between front end and copy engine.
// Depends on blz_pkg.
`default_nettype none

module blz_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  wire blz_pkg::cmd_t wr_cmd,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output blz_pkg::cmd_t      rd_cmd
);

	blz_pkg::cmd_t   mem_q [blz_pkg::QDEPTH];
	blz_pkg::q_addr_t wr_ptr_q;
	blz_pkg::q_addr_t rd_ptr_q;
	blz_pkg::q_cnt_t  cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = cnt_q != blz_pkg::q_cnt_t'(blz_pkg::QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_cmd   = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	function automatic blz_pkg::q_addr_t ptr_inc(input blz_pkg::q_addr_t p);
		ptr_inc = (p == blz_pkg::q_addr_t'(blz_pkg::QDEPTH - 1)) ? '0
			: p + blz_pkg::q_addr_t'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + blz_pkg::q_cnt_t'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - blz_pkg::q_cnt_t'(1);
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= blz_pkg::q_cnt_t'(blz_pkg::QDEPTH))
		else $error("queue count beyond depth");
	a_empty_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> !do_rd)
		else $error("read from empty queue");
	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> cnt_q == $past(cnt_q) + blz_pkg::q_cnt_t'(1))
		else $error("queue count not tracking writes");
`endif

endmodule

`default_nettype wire

/* sv/blz_back.sv */
// Copy engine: expands commands into bytes, keeps the history window, drives results.
// Depends on blz_pkg.
`default_nettype none

module blz_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire blz_pkg::cmd_t cmd,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_byte,
	output logic               out_last,
	output logic               out_bad
);

	// active command
	logic                  act_q;
	blz_pkg::cmd_kind_t    kind_q;
	logic [7:0]            data_q;
	blz_pkg::rem_t         rem_q;
	blz_pkg::dist_t        dist_q;
	logic                  fin_q;
	blz_pkg::win_addr_t    wp_q;
	blz_pkg::cnt_t         cnt_q;

	// read stage
	logic                  v_s1;
	logic                  lit_s1;
	logic                  bad_s1;
	logic                  last_s1;
	logic [7:0]            data_s1;
	blz_pkg::win_addr_t    wp_s1;
	logic [7:0]            rd_data_q;

	// output register
	logic                  out_v_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;
	logic                  out_bad_q;

	logic [7:0]            hist_mem [blz_pkg::WINDOW_DEPTH];

	logic                  s1_go;
	logic                  s1_adv;
	logic                  s1_free;
	logic                  step;
	logic                  last_step;
	logic                  issue;
	logic                  bad_now;
	logic [7:0]            val_s1;
	blz_pkg::win_ext_t     wp_ext;
	blz_pkg::win_ext_t     dist_ext;
	blz_pkg::win_ext_t     raddr_ext;
	blz_pkg::win_addr_t    raddr;
	blz_pkg::win_addr_t    wp_inc;

	assign s1_go     = !out_v_q || out_ready;
	assign s1_adv    = v_s1 && s1_go;
	assign s1_free   = !v_s1 || s1_go;
	assign step      = act_q && ((kind_q == blz_pkg::CMD_CLR) || s1_free);
	assign last_step = step && ((kind_q == blz_pkg::CMD_CLR) || (rem_q == blz_pkg::rem_t'(1)));
	assign issue     = step && (kind_q != blz_pkg::CMD_CLR);
	assign cmd_ready = !act_q || last_step;

	assign bad_now   = (kind_q == blz_pkg::CMD_REF) && (blz_pkg::cnt_t'(dist_q) > cnt_q);
	assign wp_ext    = blz_pkg::win_ext_t'(wp_q);
	assign dist_ext  = blz_pkg::win_ext_t'(dist_q);
	assign raddr_ext = (wp_ext >= dist_ext) ? wp_ext - dist_ext
		: wp_ext + blz_pkg::win_ext_t'(blz_pkg::WINDOW_DEPTH) - dist_ext;
	assign raddr     = raddr_ext[blz_pkg::WIN_AW-1:0];
	assign wp_inc    = (wp_q == blz_pkg::win_addr_t'(blz_pkg::WINDOW_DEPTH - 1)) ? '0
		: wp_q + blz_pkg::win_addr_t'(1);
	assign val_s1    = lit_s1 ? data_s1 : (bad_s1 ? 8'd0 : rd_data_q);

	assign out_valid = out_v_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_bad   = out_bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			wp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				act_q <= 1'b1;
			end else if (last_step) begin
				act_q <= 1'b0;
			end
			if (last_step && fin_q) begin
				wp_q  <= '0;
				cnt_q <= '0;
			end else if (issue) begin
				wp_q <= wp_inc;
				if (cnt_q != blz_pkg::cnt_t'(blz_pkg::WINDOW_DEPTH)) begin
					cnt_q <= cnt_q + blz_pkg::cnt_t'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			kind_q <= cmd.kind;
			data_q <= cmd.data;
			fin_q  <= cmd.fin;
			dist_q <= blz_pkg::dist_t'(cmd.dist_code) + blz_pkg::dist_t'(blz_pkg::DIST_BIAS);
			if (cmd.kind == blz_pkg::CMD_REF) begin
				rem_q <= blz_pkg::rem_t'(cmd.len_code) + blz_pkg::rem_t'(blz_pkg::LEN_BIAS);
			end else begin
				rem_q <= blz_pkg::rem_t'(1);
			end
		end else if (step) begin
			rem_q <= rem_q - blz_pkg::rem_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (issue) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			lit_s1  <= kind_q == blz_pkg::CMD_LIT;
			bad_s1  <= bad_now;
			last_s1 <= rem_q == blz_pkg::rem_t'(1);
			data_s1 <= data_q;
			wp_s1   <= wp_q;
		end
		if (s1_adv) begin
			out_byte_q <= val_s1;
			out_last_q <= last_s1;
			out_bad_q  <= bad_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			hist_mem[wp_s1] <= val_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && (kind_q == blz_pkg::CMD_REF)) begin
			rd_data_q <= hist_mem[raddr];
		end
	end

`ifndef SYNTH
	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_bad_q |-> out_byte_q == 8'd0)
		else $error("bad reference with non-zero byte");
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_go |=> v_s1 && $stable(wp_s1) && $stable(last_s1))
		else $error("read stage lost a stalled byte");
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		act_q && (kind_q != blz_pkg::CMD_CLR) |-> rem_q != '0)
		else $error("active command with no bytes left");
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue && (kind_q == blz_pkg::CMD_REF)
		|-> dist_q >= blz_pkg::dist_t'(blz_pkg::DIST_BIAS))
		else $error("reference distance below minimum");
`endif

endmodule

`default_nettype wire

/* sv/backward_lz_decompressor.sv */
// Backward LZ77 decompressor top level: front end, command queue, copy engine.
// Depends on blz_pkg, blz_front, blz_queue, blz_back.
//
// Compressed bytes enter last byte first on s_axis, tlast marking the final byte of
// a region, after which all state returns to reset. Decompressed bytes leave on
// m_axis in production (reverse) order, one per cycle at best while m_axis is ready,
// as the history window has a single read port: a literal yields one byte and a
// reference its length (3 to 18 bytes). Flag bytes and reference high bytes produce
// no output. A four-entry command queue lets input continue while a long copy runs.
// m_axis tlast marks the last byte caused by one input beat; tuser flags a byte
// whose reference reached before the produced data (emitted as zero).
// The history window needs no clearing after reset.
`default_nettype none

module backward_lz_decompressor (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] comp_byte
	input  wire logic       s_axis_tlast,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] out_byte
	output logic            m_axis_tlast,
	output logic [0:0]      m_axis_tuser   // [0] bad_reference
);

	logic          f_valid;
	logic          f_ready;
	blz_pkg::cmd_t f_cmd;
	logic          q_valid;
	logic          q_ready;
	blz_pkg::cmd_t q_cmd;
	logic          bad;

	blz_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_final  (s_axis_tlast),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	blz_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_cmd   (f_cmd),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_cmd   (q_cmd)
	);

	blz_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_bad   (bad)
	);

	assign m_axis_tuser = bad;

endmodule

`default_nettype wire
